[rtl/uvt_pkg.sv]
// uvt_pkg: sizes, command codes, token and result types of the unique value table
// no dependencies; used by every other file of the block
package uvt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int VALUE_BITS  = 32;
	localparam int POS_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);

	// field widths of the channels
	localparam int CMD_BITS      = 2;
	localparam int DATA_BITS     = 32;
	localparam int COUNT_BITS    = 32;
	localparam int SELECT_BITS   = 8;
	localparam int POSITION_BITS = 8;
	localparam int TOTAL_BITS    = 9;

	// common width for comparing the read select with a cell position
	localparam int SEL_CMP_BITS = (SELECT_BITS > FILL_BITS) ? SELECT_BITS : FILL_BITS;

	// bits of a value that take part in the compare
	localparam logic [DATA_BITS-1:0] CMP_MASK = (VALUE_BITS >= DATA_BITS) ? '1 :
		DATA_BITS'((64'd1 << VALUE_BITS) - 64'd1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// command codes
	typedef logic [CMD_BITS-1:0] cmd_t;
	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_READ   = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;

	// sequencer states of the top level
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WALK
	} state_t;

	// what travels from cell to cell
	typedef struct packed {
		logic                   is_insert;
		logic                   is_read;
		logic [DATA_BITS-1:0]   value;
		logic [SELECT_BITS-1:0] select;
		logic                   found;
		logic                   placed;
		logic [POS_BITS-1:0]    position;
		logic [DATA_BITS-1:0]   hit_value;
		logic [COUNT_BITS-1:0]  hit_count;
	} token_t;

	// one result item
	typedef struct packed {
		logic [POSITION_BITS-1:0] position;
		logic                     first;
		logic                     full;
		logic [DATA_BITS-1:0]     value;
		logic [COUNT_BITS-1:0]    count;
		logic [TOTAL_BITS-1:0]    total;
	} result_t;

endpackage

[rtl/uvt_in_if.sv]
// uvt_in_if: request channel of the unique value table, valid/ready with payload
// depends on uvt_pkg for field widths
interface uvt_in_if;
	logic                                valid;
	logic                                ready;
	uvt_pkg::cmd_t                       command;
	logic signed [uvt_pkg::DATA_BITS-1:0] element_value;
	logic [uvt_pkg::SELECT_BITS-1:0]     entry_select;

	modport source (output valid, command, element_value, entry_select, input ready);
	modport sink (input valid, command, element_value, entry_select, output ready);
	modport monitor (input valid, ready, command, element_value, entry_select);
endinterface

[rtl/uvt_out_if.sv]
// uvt_out_if: response channel of the unique value table, valid/ready with payload
// depends on uvt_pkg for field widths
interface uvt_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [uvt_pkg::POSITION_BITS-1:0]     element_position;
	logic                                  first_seen;
	logic                                  table_full;
	logic signed [uvt_pkg::DATA_BITS-1:0]  entry_value;
	logic [uvt_pkg::COUNT_BITS-1:0]        entry_count;
	logic [uvt_pkg::TOTAL_BITS-1:0]        distinct_total;

	modport source (output valid, element_position, first_seen, table_full, entry_value,
		entry_count, distinct_total, input ready);
	modport sink (input valid, element_position, first_seen, table_full, entry_value,
		entry_count, distinct_total, output ready);
	modport monitor (input valid, ready, element_position, first_seen, table_full,
		entry_value, entry_count, distinct_total);
endinterface

[rtl/uvt_cell.sv]
// uvt_cell: one table entry with its compare, count update and token register
// depends on uvt_pkg for the token type and sizes
module uvt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [uvt_pkg::POS_BITS-1:0]  cell_index,
	input  logic [uvt_pkg::FILL_BITS-1:0] fill_level,
	input  logic                          upstream_valid,
	input  uvt_pkg::token_t               upstream_token,
	output logic                          downstream_valid,
	output uvt_pkg::token_t               downstream_token
);

	logic [uvt_pkg::DATA_BITS-1:0]  value_q;
	logic [uvt_pkg::COUNT_BITS-1:0] count_q;
	logic                           token_valid_q;
	uvt_pkg::token_t                token_q;

	logic                           in_range;
	logic                           at_fill;
	logic                           sel_hit;
	logic                           match;
	logic                           place;
	logic                           pick;
	logic [uvt_pkg::COUNT_BITS-1:0] bumped;
	uvt_pkg::token_t                token_c;

	// position of this cell against the fill level and the read select
	assign in_range = uvt_pkg::FILL_BITS'(cell_index) < fill_level;
	assign at_fill  = uvt_pkg::FILL_BITS'(cell_index) == fill_level;
	assign sel_hit  = uvt_pkg::SEL_CMP_BITS'(upstream_token.select) ==
		uvt_pkg::SEL_CMP_BITS'(cell_index);

	// what the passing token does here
	assign match = upstream_valid && upstream_token.is_insert && !upstream_token.found &&
		in_range && (((value_q ^ upstream_token.value) & uvt_pkg::CMP_MASK) == '0);
	assign place = upstream_valid && upstream_token.is_insert && !upstream_token.found &&
		at_fill;
	assign pick  = upstream_valid && upstream_token.is_read && in_range && sel_hit;

	// saturating count increment
	assign bumped = (count_q == uvt_pkg::COUNT_MAX) ? count_q :
		count_q + uvt_pkg::COUNT_BITS'(1);

	// token update
	always_comb begin
		token_c = upstream_token;
		if (match) begin
			token_c.found     = 1'b1;
			token_c.position  = cell_index;
			token_c.hit_value = value_q;
			token_c.hit_count = bumped;
		end else if (place) begin
			token_c.found     = 1'b1;
			token_c.placed    = 1'b1;
			token_c.position  = cell_index;
			token_c.hit_value = upstream_token.value;
			token_c.hit_count = uvt_pkg::COUNT_BITS'(1);
		end else if (pick) begin
			token_c.hit_value = value_q;
			token_c.hit_count = count_q;
		end
	end

	// entry storage and token payload
	always_ff @(posedge clk) begin
		if (match) begin
			count_q <= bumped;
		end else if (place) begin
			value_q <= upstream_token.value;
			count_q <= uvt_pkg::COUNT_BITS'(1);
		end
		token_q <= token_c;
	end

	// token presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
		end else begin
			token_valid_q <= upstream_valid;
		end
	end

	assign downstream_valid = token_valid_q;
	assign downstream_token = token_q;

endmodule

[rtl/unique_value_table.sv]
// unique_value_table: top level, request sequencer, cell chain and result buffering
// depends on uvt_pkg, uvt_in_if, uvt_out_if and uvt_cell

// Distinct-value table with occurrence counts. Insert and read commands send a
// token down a chain of TABLE_DEPTH cells, one cell per clock; the cell that
// holds the value, the first free cell, or the selected cell acts on it. Their
// result is registered at the output once the token leaves the last cell, and
// one such request is in the chain at a time, so no further request is taken
// until the token has left the chain. Clear and the unused command code finish
// without the walk and give their result straight to the result buffering.
// A result waiting on the response side does not block the next request; a
// second finished result waits in a spare register until the first is taken.
// Entries beyond the fill level are never compared or read, so the table
// needs no clearing after reset.
module unique_value_table (
	input logic      clk,
	input logic      arst_n,
	uvt_in_if.sink   request,
	uvt_out_if.source response
);

	localparam int DEPTH = uvt_pkg::TABLE_DEPTH;

	uvt_pkg::state_t                state_q;
	uvt_pkg::state_t                state_c;
	logic [uvt_pkg::FILL_BITS-1:0]  fill_q;
	logic [uvt_pkg::FILL_BITS-1:0]  fill_inc;
	uvt_pkg::result_t               out_q;
	logic                           out_valid_q;
	uvt_pkg::result_t               pend_q;
	logic                           pend_valid_q;

	logic                           in_ready;
	logic                           accept;
	logic                           walk_start;
	logic                           is_clear;
	logic                           take;
	logic                           done_c;
	uvt_pkg::result_t               res_c;
	uvt_pkg::token_t                head_token;
	uvt_pkg::token_t                tail_token;
	logic                           exit_valid;

	logic                           chain_valid [DEPTH+1];
	uvt_pkg::token_t                chain_token [DEPTH+1];

	// request handshake
	assign in_ready      = (state_q == uvt_pkg::ST_IDLE) && !pend_valid_q;
	assign request.ready = in_ready;
	assign accept        = request.valid && in_ready;
	assign walk_start    = accept && ((request.command == uvt_pkg::CMD_INSERT) ||
		(request.command == uvt_pkg::CMD_READ));
	assign is_clear      = request.command == uvt_pkg::CMD_CLEAR;

	// token entering the chain
	always_comb begin
		head_token           = '0;
		head_token.is_insert = request.command == uvt_pkg::CMD_INSERT;
		head_token.is_read   = request.command == uvt_pkg::CMD_READ;
		head_token.value     = $unsigned(request.element_value);
		head_token.select    = request.entry_select;
	end

	assign chain_valid[0] = walk_start;
	assign chain_token[0] = head_token;

	// row of table cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		uvt_cell u_cell (
			.clk              (clk),
			.arst_n           (arst_n),
			.cell_index       (uvt_pkg::POS_BITS'(g)),
			.fill_level       (fill_q),
			.upstream_valid   (chain_valid[g]),
			.upstream_token   (chain_token[g]),
			.downstream_valid (chain_valid[g+1]),
			.downstream_token (chain_token[g+1])
		);
	end

	assign exit_valid = chain_valid[DEPTH];
	assign tail_token = chain_token[DEPTH];
	assign fill_inc   = fill_q + uvt_pkg::FILL_BITS'(1);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvt_pkg::ST_IDLE;
		end else begin
			state_q <= state_c;
		end
	end

	// next state
	always_comb begin
		state_c = state_q;
		unique case (state_q)
			uvt_pkg::ST_IDLE: begin
				if (walk_start) state_c = uvt_pkg::ST_WALK;
			end
			uvt_pkg::ST_WALK: begin
				if (exit_valid) state_c = uvt_pkg::ST_IDLE;
			end
			default: state_c = uvt_pkg::ST_IDLE;
		endcase
	end

	// result of the finished command
	always_comb begin
		res_c  = '0;
		done_c = 1'b0;
		priority if (exit_valid) begin
			done_c      = 1'b1;
			res_c.value = tail_token.hit_value;
			res_c.count = tail_token.hit_count;
			if (tail_token.is_insert) begin
				res_c.position = uvt_pkg::POSITION_BITS'(tail_token.position);
				res_c.first    = !tail_token.found || tail_token.placed;
				res_c.full     = !tail_token.found;
				res_c.total    = uvt_pkg::TOTAL_BITS'(tail_token.placed ? fill_inc : fill_q);
			end else begin
				res_c.total = uvt_pkg::TOTAL_BITS'(fill_q);
			end
		end else if (accept && is_clear) begin
			done_c = 1'b1;
		end else if (accept && !walk_start) begin
			done_c      = 1'b1;
			res_c.total = uvt_pkg::TOTAL_BITS'(fill_q);
		end else begin
			done_c = 1'b0;
		end
	end

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && is_clear) begin
			fill_q <= '0;
		end else if (exit_valid && tail_token.placed) begin
			fill_q <= fill_inc;
		end
	end

	// output register and spare slot
	assign take = out_valid_q && response.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q) begin
				if (take) pend_valid_q <= 1'b0;
			end else if (done_c) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q) begin
			if (take) out_q <= pend_q;
		end else if (done_c) begin
			if (!out_valid_q || take) begin
				out_q <= res_c;
			end else begin
				pend_q <= res_c;
			end
		end
	end

	// response payload
	assign response.valid            = out_valid_q;
	assign response.element_position = out_q.position;
	assign response.first_seen       = out_q.first;
	assign response.table_full       = out_q.full;
	assign response.entry_value      = $signed(out_q.value);
	assign response.entry_count      = out_q.count;
	assign response.distinct_total   = out_q.total;

endmodule

[rtl/uvt_checker.sv]
// uvt_checker: port-level assertions for the unique value table, bound to the top
// depends on uvt_pkg; its ports are tied to the top level's channel signals
module uvt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input uvt_pkg::cmd_t                     req_command,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [uvt_pkg::POSITION_BITS-1:0] rsp_element_position,
	input logic                              rsp_first_seen,
	input logic                              rsp_table_full,
	input logic [uvt_pkg::COUNT_BITS-1:0]    rsp_entry_count,
	input logic [uvt_pkg::TOTAL_BITS-1:0]    rsp_distinct_total
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
	else $error("response dropped while stalled");

	// an insert or read occupies the chain, so no request follows at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && ((req_command == uvt_pkg::CMD_INSERT) ||
		(req_command == uvt_pkg::CMD_READ))) |=> !req_ready)
	else $error("request taken while the chain is busy");

	// a clear into an empty output gives an empty-table result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_command == uvt_pkg::CMD_CLEAR) &&
		!rsp_valid) |=> (rsp_valid && (rsp_distinct_total == '0)))
	else $error("clear result missing or nonzero total");

	// a rejected new value reports no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_table_full) |->
		(rsp_first_seen && (rsp_entry_count == '0) &&
		(rsp_element_position == '0)))
	else $error("full-table result carries entry data");

endmodule

bind unique_value_table uvt_checker u_uvt_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.req_valid            (request.valid),
	.req_ready            (request.ready),
	.req_command          (request.command),
	.rsp_valid            (response.valid),
	.rsp_ready            (response.ready),
	.rsp_element_position (response.element_position),
	.rsp_first_seen       (response.first_seen),
	.rsp_table_full       (response.table_full),
	.rsp_entry_count      (response.entry_count),
	.rsp_distinct_total   (response.distinct_total)
);
